[rtl/core/rmsw_pkg.sv]
// Shared types and constants of the running median block.
package rmsw_pkg;

  localparam int unsigned WINDOW_CAP = 127;
  localparam int unsigned SMP_W      = 32;
  localparam int unsigned MED_W      = 33;
  localparam int unsigned AW         = 7;

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic signed [MED_W-1:0] median_t;
  typedef logic [AW-1:0]           idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FILL,
    ST_SHIFT,
    ST_EMIT
  } rmsw_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic fill;
    logic shift;
    logic emit;
  } rmsw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic want;
    logic fill_done;
    logic shift_done;
    logic slot_free;
    logic more;
  } rmsw_sts_t;

endpackage

[rtl/core/rmsw_if.sv]
// Handshake channel interfaces: sample input, median output, width config.
interface rmsw_in_if import rmsw_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface rmsw_out_if import rmsw_pkg::*; ();
  logic    valid;
  logic    ready;
  median_t median_x2;
  logic    last_of_run;
  modport source (output valid, median_x2, last_of_run, input ready);
  modport sink   (input valid, median_x2, last_of_run, output ready);
endinterface

interface rmsw_cfg_if ();
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/core/running_median_shrinking_window.sv]
// Top level of the running median filter with a shrinking window.
//
// Channels: in_i takes one sample beat (sample, last_sample); out_o gives
// result beats (median_x2 = twice the median, last_of_run); cfg_i writes
// window_width, half = width/2. Write cfg only while the block is idle.
// Each input beat is written to a 127-entry sample ring. Once half+1
// samples of a series are in, a beat yields one result; the last_sample
// beat yields up to half+1 results, oldest center first, then the series
// restarts. Each result reloads a sorted cell chain from the ring one
// sample a cycle, then shifts it toward cell 0 to reach the middle of a
// window of m samples (m <= 127); a decide step follows each input beat.
// The loading pace is set by the single ring read port. An input with
// no result passes through the decide step alone.
// The result sits in an output register; the block accepts its next input
// while that beat waits. If the receiver stalls with a result pending, the
// next result waits in the chain. Reset clears width, counters and the
// output valid; the ring needs no clearing pass.
module running_median_shrinking_window import rmsw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmsw_in_if.sink      in_i,
  rmsw_out_if.source   out_o,
  rmsw_cfg_if.sink     cfg_i
);

  rmsw_cmd_t cmd;
  rmsw_sts_t sts;

  assign cfg_i.ready = 1'b1;

  rmsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmsw_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (in_i.sample),
    .last_i        (in_i.last_sample),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .median_o      (out_o.median_x2),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule

[rtl/core/rmsw_ctrl.sv]
// Sequencer of the running median block.
module rmsw_ctrl import rmsw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  rmsw_sts_t sts_i,
  output rmsw_cmd_t cmd_o
);

  rmsw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: state_d = sts_i.want ? ST_FILL : ST_IDLE;
      ST_FILL:   if (sts_i.fill_done) state_d = ST_SHIFT;
      ST_SHIFT:  if (sts_i.shift_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.slot_free) state_d = sts_i.more ? ST_FILL : ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DECIDE: cmd_o.decide = 1'b1;
      ST_FILL:   cmd_o.fill   = 1'b1;
      ST_SHIFT:  cmd_o.shift  = 1'b1;
      ST_EMIT:   cmd_o.emit   = sts_i.slot_free;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/core/rmsw_dp.sv]
// Datapath: sample ring, sorted cell chain, window bookkeeping, output register.
module rmsw_dp import rmsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rmsw_cmd_t  cmd_i,
  output rmsw_sts_t  sts_o,
  input  sample_t    sample_i,
  input  logic       last_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output median_t    median_o,
  output logic       last_of_run_o
);

  localparam idx_t CAP_M1 = idx_t'(WINDOW_CAP - 1);

  // sample ring
  sample_t ring_q [WINDOW_CAP];
  sample_t rd_data_q;
  logic    rd_pend_q;

  logic [6:0] width_q;
  idx_t       wp_q, rc_q, slot_q, oldest_q;
  logic       last_q;
  idx_t       c_q, hi_q, age_q, addr_q, n_q;
  logic [5:0] shcnt_q;
  logic       ovalid_q, olast_q;
  median_t    omed_q;

  sample_t cell_q [WINDOW_CAP];
  sample_t cell_d [WINDOW_CAP];
  logic    gt     [WINDOW_CAP];

  logic [5:0] half;
  idx_t       half7, rc_inc, c_first, hi_first, c_next, hi_next, sum_c;
  logic       issue, insert, more;

  assign half  = width_q[6:1];
  assign half7 = {1'b0, half};
  assign rc_inc = (rc_q == CAP_M1 + 7'd1) ? rc_q : rc_q + 7'd1;

  always_comb begin
    c_first  = (oldest_q < half7) ? oldest_q : half7;
    sum_c    = c_first + half7;
    if (last_q) begin
      hi_first = (sum_c > oldest_q) ? oldest_q : sum_c;
    end else begin
      hi_first = ({half, 1'b0} > oldest_q) ? oldest_q : {half, 1'b0};
    end
    c_next  = c_q - 7'd1;
    hi_next = ((c_next + half7) > oldest_q) ? oldest_q : (c_next + half7);
  end

  assign more   = last_q && (c_q != '0);
  assign issue  = cmd_i.fill && (age_q <= hi_q) && (age_q != CAP_M1 + 7'd1);
  assign insert = cmd_i.fill && rd_pend_q;

  assign sts_o.want       = last_q || (oldest_q >= half7);
  assign sts_o.fill_done  = !issue && !rd_pend_q;
  assign sts_o.shift_done = (shcnt_q == '0);
  assign sts_o.slot_free  = !ovalid_q || out_ready_i;
  assign sts_o.more       = more;

  // ring write on input beat, registered read during fill
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) ring_q[wp_q] <= sample_i;
    if (issue) rd_data_q <= ring_q[addr_q];
  end

  // insertion into the sorted chain, or shift toward cell 0
  always_comb begin
    for (int k = 0; k < WINDOW_CAP; k++) begin
      gt[k] = (idx_t'(k) < n_q) && (cell_q[k] > rd_data_q);
    end
    for (int k = 0; k < WINDOW_CAP; k++) begin
      cell_d[k] = cell_q[k];
      if (insert) begin
        if (k > 0 && gt[k-1]) begin
          cell_d[k] = cell_q[k-1];
        end else if (gt[k] || idx_t'(k) == n_q) begin
          cell_d[k] = rd_data_q;
        end
      end else if (cmd_i.shift && shcnt_q != '0 && k < WINDOW_CAP - 1) begin
        cell_d[k] = cell_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < WINDOW_CAP; k++) cell_q[k] <= cell_d[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= '0;
      wp_q      <= '0;
      rc_q      <= '0;
      slot_q    <= '0;
      oldest_q  <= '0;
      last_q    <= 1'b0;
      c_q       <= '0;
      hi_q      <= '0;
      age_q     <= '0;
      addr_q    <= '0;
      n_q       <= '0;
      shcnt_q   <= '0;
      rd_pend_q <= 1'b0;
      ovalid_q  <= 1'b0;
      olast_q   <= 1'b0;
    end else begin
      if (cfg_we_i) width_q <= cfg_data_i;
      rd_pend_q <= issue;
      if (issue) begin
        age_q  <= age_q + 7'd1;
        addr_q <= (addr_q == '0) ? CAP_M1 : addr_q - 7'd1;
      end
      if (insert) n_q <= n_q + 7'd1;
      if (cmd_i.shift && shcnt_q != '0) shcnt_q <= shcnt_q - 6'd1;
      if (cmd_i.accept) begin
        slot_q   <= wp_q;
        wp_q     <= (wp_q == CAP_M1) ? '0 : wp_q + 7'd1;
        rc_q     <= rc_inc;
        oldest_q <= rc_inc - 7'd1;
        last_q   <= last_i;
      end
      if (cmd_i.decide) begin
        c_q     <= c_first;
        hi_q    <= hi_first;
        age_q   <= '0;
        addr_q  <= slot_q;
        n_q     <= '0;
        shcnt_q <= hi_first[6:1];
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        olast_q  <= !last_q || (c_q == '0);
        if (more) begin
          c_q     <= c_next;
          hi_q    <= hi_next;
          age_q   <= '0;
          addr_q  <= slot_q;
          n_q     <= '0;
          shcnt_q <= hi_next[6:1];
        end else if (last_q) begin
          wp_q <= '0;
          rc_q <= '0;
        end
      end
    end
  end

  // odd count: twice the middle; even: sum of the two middles
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (hi_q[0] == 1'b0) omed_q <= {cell_q[0], 1'b0};
      else omed_q <= {cell_q[0][SMP_W-1], cell_q[0]} + {cell_q[1][SMP_W-1], cell_q[1]};
    end
  end

  assign out_valid_o   = ovalid_q;
  assign median_o      = omed_q;
  assign last_of_run_o = olast_q;

  a_chain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> ({1'b0, n_q} <= {1'b0, hi_q} + 8'd1))
    else $error("chain holds more than the window");
  a_wp_tracks_rc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rc_q != CAP_M1 + 7'd1) |-> (wp_q == rc_q))
    else $error("write pointer out of step with count");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!ovalid_q || out_ready_i))
    else $error("output register overwritten");
  a_c_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill && last_q) |-> (c_q <= half7))
    else $error("flush center beyond half");

endmodule

[tb/sv/rmsw_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard package: running median predictor and result checker.
package rmsw_tb_pkg;
  import rmsw_pkg::*;

  typedef struct packed {
    median_t med;
    logic    last;
  } med_res_t;

  class median_scoreboard;
    sample_t  ring[WINDOW_CAP];
    int       rcv_cnt;
    int       wr_ptr;
    int       width;
    med_res_t pending[$];
    int       errors;
    int       n_checked;
    int       n_flush_multi;

    function void clear();
      rcv_cnt = 0;
      wr_ptr = 0;
      width = 0;
      errors = 0;
      n_checked = 0;
      n_flush_multi = 0;
      pending.delete();
    endfunction

    function void set_width(int w);
      width = w & 8'h7f;
    endfunction

    function sample_t at_age(int age);
      return ring[(wr_ptr + 2 * WINDOW_CAP - 1 - (age % WINDOW_CAP)) % WINDOW_CAP];
    endfunction

    // Twice the median over ages lo..hi, via insertion sort.
    function median_t median_x2(int lo, int hi);
      longint vals[$];
      longint v;
      int k;
      int m;
      for (int a = lo; a <= hi; a++) begin
        v = longint'(at_age(a));
        k = 0;
        while (k < vals.size() && vals[k] <= v) k++;
        vals.insert(k, v);
      end
      m = vals.size();
      if (m == 0) return '0;
      if (m % 2) return median_t'(2 * vals[m / 2]);
      return median_t'(vals[m / 2 - 1] + vals[m / 2]);
    endfunction

    function void note_sample(sample_t s, logic last);
      int half;
      int oldest;
      int hi;
      int lo;
      int c;
      med_res_t r;
      half = width / 2;
      if (half > (WINDOW_CAP - 1) / 2) half = (WINDOW_CAP - 1) / 2;
      ring[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % WINDOW_CAP;
      if (rcv_cnt < WINDOW_CAP) rcv_cnt++;
      oldest = rcv_cnt - 1;
      if (!last) begin
        if (oldest >= half) begin
          hi = (2 * half > oldest) ? oldest : 2 * half;
          r.med = median_x2(0, hi);
          r.last = 1'b1;
          pending.push_back(r);
        end
      end else begin
        c = (oldest < half) ? oldest : half;
        if (c > 0) n_flush_multi++;
        while (1) begin
          lo = (c > half) ? c - half : 0;
          hi = (c + half > oldest) ? oldest : c + half;
          r.med = median_x2(lo, hi);
          r.last = (c == 0);
          pending.push_back(r);
          if (c == 0) break;
          c--;
        end
        rcv_cnt = 0;
        wr_ptr = 0;
      end
    endfunction

    function void check_result(median_t med, logic last);
      med_res_t e;
      n_checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result med=%0d last=%0b", $time, med, last);
        return;
      end
      e = pending.pop_front();
      if (e.med !== med) begin
        errors++;
        $display("%0t: median_x2 exp=%0d act=%0d", $time, e.med, med);
      end
      if (e.last !== last) begin
        errors++;
        $display("%0t: last_of_run exp=%0b act=%0b", $time, e.last, last);
      end
    endfunction
  endclass
endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top testbench for the running median filter with shrinking window.
module tb_top;
  import rmsw_pkg::*;
  import rmsw_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_GAP   = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmsw_in_if  in_ch ();
  rmsw_out_if out_ch ();
  rmsw_cfg_if cfg_ch ();

  running_median_shrinking_window u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  median_scoreboard sb;
  bit quiet_tail;      // no idling on either side near the end
  bit long_hold;       // receiver holds ready low for a long stretch
  int idle_cnt;
  int n_beats;
  int n_long_series;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // Receiver: random stall bursts, or one long hold when asked.
  initial begin
    int gap;
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 300; hold++) @(posedge clk_i);
        long_hold = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor, sampled on the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.median_x2, out_ch.last_of_run);
  end

  // Watchdog: cycles with no beat accepted anywhere.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(sample_t s, logic last);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.last_sample <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_sample(s, last);
    n_beats++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all expected beats, then let the chain settle before a config write.
  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic write_width(int w);
    drop_valid();
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w[6:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_width(w);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic sample_t rand_sample(int mode);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(0, 20)) - 10;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return sample_t'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // One series of random content; short ones mostly, one past the ring size.
  task automatic send_series(int len, int mode);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(mode), i == len - 1);
  endtask

  initial begin
    int len;
    int w;
    int remaining;
    int widths[$];
    sb = new();
    sb.clear();
    idle_cnt = 0;
    n_beats = 0;
    n_long_series = 0;
    quiet_tail = 1'b0;
    long_hold = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: width zero passes samples through, doubled.
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(32'sh00000000, 1'b1);
    // Width 5 (half 2): warm-up, shrinking ends, even-count sums of extremes.
    write_width(5);
    send_sample(32'sh7fffffff, 1'b0);
    send_sample(32'sh7ffffffe, 1'b0);
    send_sample(32'sh80000000, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(32'sh80000001, 1'b0);
    send_sample(1, 1'b1);
    // Series shorter than half: last beat alone flushes.
    write_width(8);
    send_sample(100, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(7, 1'b1);
    // Widest and saturated widths, with a width change inside a series.
    write_width(127);
    send_sample(32'sh55555555, 1'b0);
    send_sample(32'shaaaaaaaa, 1'b0);
    send_sample(42, 1'b0);
    write_width(2);
    send_sample(-42, 1'b0);
    send_sample(9, 1'b0);
    send_sample(-9, 1'b1);
    write_width(126);
    send_series(5, 2);

    // Random phases over several widths; extremes included.
    widths = '{0, 1, 126, 127, 3, 10, 31, 64, 7, 20};
    remaining = 470;
    foreach (widths[k]) begin
      w = widths[k];
      write_width(w);
      if (k == 4) begin
        // Long series that wraps the ring with the widest window is costly;
        // use a small width for that.
        send_series(140, 3);
        n_long_series++;
        remaining -= 140;
      end
      if (k == 3) begin
        // Long receiver hold while the sender keeps offering beats.
        long_hold = 1'b1;
        send_series(20, 1);
        remaining -= 20;
      end
      if (k == 6) begin
        // Sender pauses until every expected beat has come.
        send_series(6, 0);
        drop_valid();
        while (sb.pending.size() != 0) @(posedge clk_i);
        remaining -= 6;
      end
      if (k == widths.size() - 1) quiet_tail = 1'b1;
      for (int j = 0; j < ((w > 60) ? 3 : 6) && remaining > 0; j++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) :
              $urandom_range(1, (w > 60) ? 80 : 30);
        send_series(len, $urandom_range(0, 3));
        remaining -= len;
      end
    end
    write_width(9);
    while (remaining > 0) begin
      len = $urandom_range(1, 25);
      send_series(len, $urandom_range(0, 3));
      remaining -= len;
    end
    drop_valid();

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
    $display("Covered %0d sample beats, %0d results checked, %0d multi-result flushes,",
             n_beats, sb.n_checked, sb.n_flush_multi);
    $display("widths 0..127 incl. saturation, ring wrap in %0d long series.", n_long_series);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/rmsw_pkg.sv
rtl/core/rmsw_if.sv
rtl/core/rmsw_ctrl.sv
rtl/core/rmsw_dp.sv
rtl/core/running_median_shrinking_window.sv
tb/sv/rmsw_tb_pkg.sv
tb/sv/tb_top.sv
